FILE: design/pfa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared types and constants for the first-fit page frame allocator.
// ----------------------------------------------------------------------------
package pfa_pkg;

    localparam int FRAME_COUNT_DEF = 8;
    localparam int TABLE_DEPTH     = 8;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_NO_FRAMES   = 2'd1;
    localparam logic [1:0] ST_ALLOCATED   = 2'd2;
    localparam logic [1:0] ST_NOTHING_REL = 2'd3;

    typedef struct packed {
        logic       action;
        logic [3:0] page_request;
    } pfa_req_t;

    typedef struct packed {
        logic [1:0] status;
        logic       mapping_valid;
        logic [2:0] page_number;
        logic [2:0] frame_number;
        logic [3:0] free_count;
        logic       last;
    } pfa_res_t;

    typedef struct packed {
        logic       capture;
        logic       emit_single;
        logic [1:0] status;
        logic       take_pages;
        logic       do_free;
        logic       emit_map;
    } pfa_cmd_t;

    typedef struct packed {
        logic action;
        logic zero_pages;
        logic fits;
        logic in_use;
        logic last_page;
    } pfa_stat_t;

endpackage

FILE: design/pfa_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_datapath
// Frame bitmap, free counter, request latch, page counter and result register.
// ----------------------------------------------------------------------------
module pfa_datapath #(
    parameter int FRAME_COUNT = pfa_pkg::FRAME_COUNT_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  pfa_pkg::pfa_req_t request,
    input  pfa_pkg::pfa_cmd_t cmd,
    output pfa_pkg::pfa_stat_t stat,
    output logic              done,
    output pfa_pkg::pfa_res_t result
);

    localparam int FW    = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
    localparam int CW    = $clog2(FRAME_COUNT + 1);
    localparam int CMP_W = (CW > 4) ? CW : 4;
    localparam int XW    = (FW > 3) ? FW : 3;

    logic [FRAME_COUNT-1:0] busy_reg, busy_next;
    logic [CW-1:0]          free_reg, free_next;
    logic                   in_use_reg, in_use_next;
    logic                   action_reg;
    logic [3:0]             want_reg;
    logic [2:0]             page_reg;
    logic                   done_reg;
    pfa_pkg::pfa_res_t      result_reg;

    logic [FW-1:0]    low_free;
    logic [XW-1:0]    low_free_ext;
    logic [CMP_W-1:0] free_ext;
    logic [CMP_W-1:0] want_ext;
    logic [3:0]       free_sat;

    always_comb
    begin
        low_free = '0;
        for (int i = FRAME_COUNT - 1; i >= 0; i--)
        begin
            if (!busy_reg[i])
            begin
                low_free = FW'(i);
            end
        end
    end

    assign low_free_ext = XW'(low_free);
    assign want_ext     = CMP_W'(want_reg);

    always_comb
    begin
        busy_next   = busy_reg;
        free_next   = free_reg;
        in_use_next = in_use_reg;
        if (cmd.do_free)
        begin
            busy_next   = '0;
            free_next   = CW'(FRAME_COUNT);
            in_use_next = 1'b0;
        end
        if (cmd.take_pages)
        begin
            free_next   = free_reg - CW'(want_reg);
            in_use_next = 1'b1;
        end
        if (cmd.emit_map)
        begin
            busy_next[low_free] = 1'b1;
        end
    end

    assign free_ext = CMP_W'(free_next);
    assign free_sat = (free_ext > CMP_W'(15)) ? 4'hF : free_ext[3:0];

    assign stat.action     = action_reg;
    assign stat.zero_pages = (want_reg == 4'd0);
    assign stat.fits       = (want_reg <= 4'(pfa_pkg::TABLE_DEPTH))
                             && (want_ext <= CMP_W'(free_reg));
    assign stat.in_use     = in_use_reg;
    assign stat.last_page  = ({1'b0, page_reg} + 4'd1 == want_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= '0;
            free_reg   <= CW'(FRAME_COUNT);
            in_use_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            free_reg   <= free_next;
            in_use_reg <= in_use_next;
            done_reg   <= cmd.emit_single | cmd.emit_map;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            action_reg <= request.action;
            want_reg   <= request.page_request;
            page_reg   <= 3'd0;
        end
        else if (cmd.emit_map)
        begin
            page_reg <= page_reg + 3'd1;
        end

        if (cmd.emit_single)
        begin
            result_reg.status        <= cmd.status;
            result_reg.mapping_valid <= 1'b0;
            result_reg.page_number   <= 3'd0;
            result_reg.frame_number  <= 3'd0;
            result_reg.free_count    <= free_sat;
            result_reg.last          <= 1'b1;
        end
        else if (cmd.emit_map)
        begin
            result_reg.status        <= pfa_pkg::ST_OK;
            result_reg.mapping_valid <= 1'b1;
            result_reg.page_number   <= page_reg;
            result_reg.frame_number  <= low_free_ext[2:0];
            result_reg.free_count    <= free_sat;
            result_reg.last          <= stat.last_page;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

FILE: design/pfa_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_controller
// Sequencer: accepts a request, decides its outcome, steps through pages.
// ----------------------------------------------------------------------------
module pfa_controller (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  pfa_pkg::pfa_stat_t stat,
    output logic               busy,
    output pfa_pkg::pfa_cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECIDE,
        S_ALLOC
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.status = pfa_pkg::ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                state_next = S_IDLE;
                if (stat.action == pfa_pkg::ACT_FREE)
                begin
                    cmd.emit_single = 1'b1;
                    if (stat.in_use)
                    begin
                        cmd.do_free = 1'b1;
                    end
                    else
                    begin
                        cmd.status = pfa_pkg::ST_NOTHING_REL;
                    end
                end
                else if (stat.in_use)
                begin
                    cmd.emit_single = 1'b1;
                    cmd.status      = pfa_pkg::ST_ALLOCATED;
                end
                else if (!stat.fits)
                begin
                    cmd.emit_single = 1'b1;
                    cmd.status      = pfa_pkg::ST_NO_FRAMES;
                end
                else
                begin
                    cmd.take_pages = 1'b1;
                    if (stat.zero_pages)
                    begin
                        cmd.emit_single = 1'b1;
                    end
                    else
                    begin
                        state_next = S_ALLOC;
                    end
                end
            end
            S_ALLOC:
            begin
                cmd.emit_map = 1'b1;
                if (stat.last_page)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

FILE: design/page_frame_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_frame_allocator
// First-fit page frame allocator holding the page table of one process.
// ----------------------------------------------------------------------------
// Usage:
//   Drive request (action, page_request) with start while busy is low; the
//   request is taken at that clock edge and busy rises in the next cycle.
//   Results appear on result with done high for exactly one cycle each; the
//   receiver cannot hold them off and must take each one as it shows.
//   A one-result request is decided in the decide state, which registers its
//   result. An allocate of N pages (1 to 8) that succeeds goes from the
//   decide state to the allocate state, which emits N results that show on
//   back-to-back cycles, one page per cycle, last set on the final one; the
//   single frame-search unit over the bitmap sets that pace. Every other
//   request gives one result. busy stays high in the decide and allocate
//   states; the next request may be taken at the edge that ends the cycle
//   the last result shows.
//   Reset frees every frame and empties the page table at once.
// ----------------------------------------------------------------------------
module page_frame_allocator #(
    parameter int FRAME_COUNT = pfa_pkg::FRAME_COUNT_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  pfa_pkg::pfa_req_t request,
    output logic              done,
    output pfa_pkg::pfa_res_t result
);

    pfa_pkg::pfa_cmd_t  cmd;
    pfa_pkg::pfa_stat_t stat;

    pfa_controller u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .busy  (busy),
        .cmd   (cmd)
    );

    pfa_datapath #(
        .FRAME_COUNT (FRAME_COUNT)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .stat    (stat),
        .done    (done),
        .result  (result)
    );

endmodule

FILE: design/pfa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_checker
// Port-level checks on request and result sequencing of the allocator.
// ----------------------------------------------------------------------------
module pfa_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input pfa_pkg::pfa_res_t result,
    input logic              done
);

    a_take_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after a request was taken");

    a_unmapped_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.mapping_valid) |->
        (result.page_number == 3'd0 && result.frame_number == 3'd0))
        else $error("result without mapping carries page or frame");

    a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != pfa_pkg::ST_OK) |->
        (result.last && !result.mapping_valid))
        else $error("error result is not a single unmapped last result");

    a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.last) |=>
        (done && result.mapping_valid
         && result.page_number == $past(result.page_number) + 3'd1))
        else $error("page burst broke off or skipped a page");

    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.last) |=> !done)
        else $error("result followed the final result without a new request");

endmodule

bind page_frame_allocator pfa_checker u_pfa_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .result (result),
    .done   (done)
);
